// ===== hw/rtl/mesp_pkg.sv =====
// ----------------------------------------------------------------------------
// MADT entry stream parser package
// Shared types, codes and sizes for the entry stream parser.
// ----------------------------------------------------------------------------
package mesp_pkg;

  localparam int unsigned CNT_W       = 13;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

  localparam logic [7:0] TYPE_LOCAL    = 8'd0;
  localparam logic [7:0] TYPE_IO       = 8'd1;
  localparam logic [7:0] TYPE_OVERRIDE = 8'd5;

  localparam logic [7:0] ENABLE_MASK = 8'h01;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_LEN_UNDER_2 = 3'd1,
    ST_PAST_END    = 3'd2,
    ST_SHORT_LOCAL = 3'd3,
    ST_SHORT_IO    = 3'd4,
    ST_UNDER_TWO   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_AREA_LENGTH = 2'd0,
    REG_BOOT_CPU_ID = 2'd1,
    REG_HEADER_ADDR = 2'd2
  } reg_index_t;

  localparam logic KIND_SLOT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              has_slot;
    logic              has_sum;
    logic [CNT_W-1:0]  slot;
    logic [7:0]        id;
    logic [CNT_W-1:0]  enabled_count;
    logic [CNT_W-1:0]  other_count;
    logic              boot_found;
    logic [ADDR_W-1:0] addr;
    status_t           sum_status;
  } event_t;

endpackage

// ===== hw/rtl/mesp_front.sv =====
// ----------------------------------------------------------------------------
// MADT entry stream parser front end
// Accepts one byte per cycle whenever the event queue has room, frames entries and produces result events.
// ----------------------------------------------------------------------------
module mesp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic [15:0]          area_length,
  input  logic [7:0]           boot_cpu_id,
  input  logic [31:0]          header_controller_addr,
  input  logic                 q_full,
  output logic                 push,
  output mesp_pkg::event_t     push_data
);

  logic [15:0]                area_pos, area_pos_next;
  logic [7:0]                 entry_pos, entry_pos_next;
  logic [7:0]                 entry_type, entry_type_next;
  logic [7:0]                 entry_len, entry_len_next;
  logic [7:0]                 latched_id, latched_id_next;
  logic                       enable_bit, enable_bit_next;
  logic [63:0]                addr_shift, addr_shift_next;
  logic [63:0]                override_addr, override_addr_next;
  logic [mesp_pkg::CNT_W-1:0] next_slot, next_slot_next;
  logic [mesp_pkg::CNT_W-1:0] enabled_total, enabled_total_next;
  logic                       boot_seen, boot_seen_next;
  mesp_pkg::status_t          stop_status, stop_status_next;
  logic                       stopped, stopped_next;

  logic                       accept;
  logic [16:0]                len_eff;
  logic signed [17:0]         left;
  logic signed [17:0]         rem;
  logic                       final_byte;
  logic                       slot_hit;
  logic [mesp_pkg::CNT_W-1:0] slot_val;
  mesp_pkg::status_t          sum_status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign len_eff    = (area_length == 16'd0) ? 17'h10000 : {1'b0, area_length};
  assign left       = $signed({1'b0, len_eff}) - $signed({2'b00, area_pos});
  assign rem        = left + 18'sd1;
  assign final_byte = (area_pos == area_length - 16'd1);

  always_comb begin
    area_pos_next      = area_pos + 16'd1;
    entry_pos_next     = entry_pos;
    entry_type_next    = entry_type;
    entry_len_next     = entry_len;
    latched_id_next    = latched_id;
    enable_bit_next    = enable_bit;
    addr_shift_next    = addr_shift;
    override_addr_next = override_addr;
    next_slot_next     = next_slot;
    enabled_total_next = enabled_total;
    boot_seen_next     = boot_seen;
    stop_status_next   = stop_status;
    stopped_next       = stopped;
    slot_hit           = 1'b0;
    slot_val           = '0;

    if (!stopped) begin
      if (entry_pos == 8'd0) begin
        if (left < 18'sd3) begin
          stopped_next = 1'b1;
        end else begin
          entry_type_next = data_byte;
          entry_pos_next  = 8'd1;
        end
      end else if (entry_pos == 8'd1) begin
        entry_len_next = data_byte;
        if (data_byte < 8'd2) begin
          stopped_next     = 1'b1;
          stop_status_next = mesp_pkg::ST_LEN_UNDER_2;
        end else if ($signed({10'd0, data_byte}) > rem) begin
          stopped_next     = 1'b1;
          stop_status_next = mesp_pkg::ST_PAST_END;
        end else if (entry_type == mesp_pkg::TYPE_LOCAL && data_byte < 8'd8) begin
          stopped_next     = 1'b1;
          stop_status_next = mesp_pkg::ST_SHORT_LOCAL;
        end else if (entry_type == mesp_pkg::TYPE_IO && data_byte < 8'd12) begin
          stopped_next     = 1'b1;
          stop_status_next = mesp_pkg::ST_SHORT_IO;
        end else if (data_byte == 8'd2) begin
          entry_pos_next = 8'd0;
        end else begin
          entry_pos_next = 8'd2;
        end
      end else begin
        if (entry_type == mesp_pkg::TYPE_LOCAL) begin
          if (entry_pos == 8'd3) begin
            latched_id_next = data_byte;
          end
          if (entry_pos == 8'd4) begin
            enable_bit_next = |(data_byte & mesp_pkg::ENABLE_MASK);
          end
        end else if (entry_type == mesp_pkg::TYPE_OVERRIDE) begin
          for (int k = 0; k < 8; k++) begin
            if (entry_pos == 8'(4 + k)) begin
              addr_shift_next[8*k +: 8] = addr_shift[8*k +: 8] | data_byte;
            end
          end
        end
        if ({1'b0, entry_pos} + 9'd1 >= {1'b0, entry_len}) begin
          if (entry_type == mesp_pkg::TYPE_LOCAL && enable_bit_next) begin
            slot_hit = 1'b1;
            if (enabled_total < mesp_pkg::CNT_MAX) begin
              enabled_total_next = enabled_total + 13'd1;
            end
            if (latched_id_next == boot_cpu_id) begin
              slot_val       = '0;
              boot_seen_next = 1'b1;
            end else begin
              slot_val = next_slot;
              if (next_slot < mesp_pkg::CNT_MAX) begin
                next_slot_next = next_slot + 13'd1;
              end
            end
          end else if (entry_type == mesp_pkg::TYPE_OVERRIDE && entry_len >= 8'd12) begin
            override_addr_next = addr_shift_next;
          end
          entry_pos_next  = 8'd0;
          addr_shift_next = '0;
          latched_id_next = '0;
          enable_bit_next = 1'b0;
        end else begin
          entry_pos_next = entry_pos + 8'd1;
        end
      end
    end

    sum_status = stop_status_next;
    if (stop_status_next == mesp_pkg::ST_OK && enabled_total_next < 13'd2) begin
      sum_status = mesp_pkg::ST_UNDER_TWO;
    end

    push_data.has_slot      = slot_hit;
    push_data.has_sum       = final_byte;
    push_data.slot          = slot_val;
    push_data.enabled_count = enabled_total_next;
    push_data.other_count   = next_slot_next - 13'd1;
    push_data.boot_found    = boot_seen_next;
    push_data.addr          = (override_addr_next != 64'd0) ? override_addr_next
                                                            : {32'd0, header_controller_addr};
    push_data.sum_status    = sum_status;

    if (slot_hit) begin
      push_data.id = (entry_pos == 8'd3) ? data_byte : latched_id;
    end else begin
      push_data.id = '0;
    end

    if (final_byte) begin
      area_pos_next      = '0;
      entry_pos_next     = '0;
      entry_type_next    = '0;
      entry_len_next     = '0;
      latched_id_next    = '0;
      enable_bit_next    = 1'b0;
      addr_shift_next    = '0;
      override_addr_next = '0;
      next_slot_next     = 13'd1;
      enabled_total_next = '0;
      boot_seen_next     = 1'b0;
      stop_status_next   = mesp_pkg::ST_OK;
      stopped_next       = 1'b0;
    end
  end

  assign push = accept && (slot_hit || final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      area_pos      <= '0;
      entry_pos     <= '0;
      entry_type    <= '0;
      entry_len     <= '0;
      latched_id    <= '0;
      enable_bit    <= 1'b0;
      addr_shift    <= '0;
      override_addr <= '0;
      next_slot     <= 13'd1;
      enabled_total <= '0;
      boot_seen     <= 1'b0;
      stop_status   <= mesp_pkg::ST_OK;
      stopped       <= 1'b0;
    end else if (accept) begin
      area_pos      <= area_pos_next;
      entry_pos     <= entry_pos_next;
      entry_type    <= entry_type_next;
      entry_len     <= entry_len_next;
      latched_id    <= latched_id_next;
      enable_bit    <= enable_bit_next;
      addr_shift    <= addr_shift_next;
      override_addr <= override_addr_next;
      next_slot     <= next_slot_next;
      enabled_total <= enabled_total_next;
      boot_seen     <= boot_seen_next;
      stop_status   <= stop_status_next;
      stopped       <= stopped_next;
    end
  end

endmodule

// ===== hw/rtl/mesp_queue.sv =====
// ----------------------------------------------------------------------------
// MADT entry stream parser event queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mesp_queue #(
  parameter int unsigned DEPTH = mesp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mesp_pkg::event_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output mesp_pkg::event_t q_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mesp_pkg::event_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mesp_back.sv =====
// ----------------------------------------------------------------------------
// MADT entry stream parser back end
// Holds one event and delivers its slot result, its summary result, or both in that order.
// ----------------------------------------------------------------------------
module mesp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  mesp_pkg::event_t            q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [mesp_pkg::CNT_W-1:0]  cpu_slot,
  output logic [7:0]                  controller_id,
  output logic [mesp_pkg::CNT_W-1:0]  enabled_count,
  output logic [mesp_pkg::CNT_W-1:0]  other_cpu_count,
  output logic                        boot_cpu_found,
  output logic [mesp_pkg::ADDR_W-1:0] controller_addr,
  output logic [2:0]                  status,
  output logic                        last_result
);

  mesp_pkg::event_t cur;
  logic             cur_valid;
  logic             phase;
  logic             take;
  logic             advance;

  assign result_kind = (cur.has_slot && !phase) ? mesp_pkg::KIND_SLOT
                                                : mesp_pkg::KIND_SUMMARY;
  assign last_result = (result_kind == mesp_pkg::KIND_SUMMARY) || !cur.has_sum;

  assign out_valid       = cur_valid;
  assign cpu_slot        = (result_kind == mesp_pkg::KIND_SLOT) ? cur.slot : '0;
  assign controller_id   = (result_kind == mesp_pkg::KIND_SLOT) ? cur.id : '0;
  assign enabled_count   = cur.enabled_count;
  assign other_cpu_count = cur.other_count;
  assign boot_cpu_found  = cur.boot_found;
  assign controller_addr = cur.addr;
  assign status          = (result_kind == mesp_pkg::KIND_SLOT) ? 3'(mesp_pkg::ST_OK)
                                                                : 3'(cur.sum_status);

  assign take    = cur_valid && out_ready;
  assign advance = !cur_valid || (take && last_result);
  assign pop     = advance && q_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (advance) begin
      cur_valid <= q_valid;
      phase     <= 1'b0;
    end else if (take) begin
      phase <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/madt_entry_stream_parser.sv =====
// ----------------------------------------------------------------------------
// MADT entry stream parser
// Parses the entry area of an interrupt controller table one byte per request
// and reports processor slot assignments and an end-of-area summary.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle whenever its event queue has
// room; the byte-by-byte framing logic in the front end updates all parse
// state as it takes a byte, so a byte never waits on an earlier one. A byte
// that completes an enabled local controller entry, or is the last byte of
// the area, writes one event into a queue of QUEUE_DEPTH entries; the back
// end loads each event into its own register and then presents its results.
// Each result is held on the output until out_ready takes it; an area's last
// byte that also ends an enabled local entry is the only byte that yields two
// results, its slot result and then the summary. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the parser is idle, as the block itself does not enforce it.
module madt_entry_stream_parser #(
  parameter int unsigned QUEUE_DEPTH = mesp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [mesp_pkg::CNT_W-1:0]  cpu_slot,
  output logic [7:0]                  controller_id,
  output logic [mesp_pkg::CNT_W-1:0]  enabled_count,
  output logic [mesp_pkg::CNT_W-1:0]  other_cpu_count,
  output logic                        boot_cpu_found,
  output logic [mesp_pkg::ADDR_W-1:0] controller_addr,
  output logic [2:0]                  status,
  output logic                        last_result
);

  logic [15:0]      area_length;
  logic [7:0]       boot_cpu_id;
  logic [31:0]      header_controller_addr;

  logic             q_full;
  logic             push;
  mesp_pkg::event_t push_data;
  logic             pop;
  logic             q_valid;
  mesp_pkg::event_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_length            <= 16'd1;
      boot_cpu_id            <= '0;
      header_controller_addr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mesp_pkg::REG_AREA_LENGTH: area_length            <= cfg_data[15:0];
        mesp_pkg::REG_BOOT_CPU_ID: boot_cpu_id            <= cfg_data[7:0];
        mesp_pkg::REG_HEADER_ADDR: header_controller_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  mesp_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .data_byte              (data_byte),
    .area_length            (area_length),
    .boot_cpu_id            (boot_cpu_id),
    .header_controller_addr (header_controller_addr),
    .q_full                 (q_full),
    .push                   (push),
    .push_data              (push_data)
  );

  mesp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  mesp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .cpu_slot        (cpu_slot),
    .controller_id   (controller_id),
    .enabled_count   (enabled_count),
    .other_cpu_count (other_cpu_count),
    .boot_cpu_found  (boot_cpu_found),
    .controller_addr (controller_addr),
    .status          (status),
    .last_result     (last_result)
  );

endmodule
